// ===== rtl/core/smm_pkg.sv =====
// shared types and constants for the three-axis sliding median filter
package smm_pkg;

  // default sizing
  localparam int WINDOW_MAX_DEF  = 16;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int AXES            = 3;

  // window length register
  localparam int          CFG_W        = 5;
  localparam logic [4:0]  WINDOW_RESET = 5'd5;

  // sequencer states, one-hot
  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_DROP   = 4'b0010,
    ST_INSERT = 4'b0100,
    ST_MEDIAN = 4'b1000
  } smm_state_t;

  // per-cycle command to every cell of every chain
  typedef struct packed {
    logic insert;
    logic delete;
  } smm_ctl_t;

endpackage

// ===== rtl/core/sliding_median_three_axis.sv =====
// top level of the three-axis sliding median filter
//
//  channel   dir  handshake                 payload
//  s_        in   s_tvalid / s_tready       s_tdata: sample_x, sample_y, sample_z
//  m_        out  m_tvalid / m_tready       m_tdata: median_x, median_y, median_z
//  cfg_      in   cfg_we                    cfg_wdata: window_length
//
// an accepted word passes the per-item sequencer: d drop steps, d being the number of
// oldest samples dropped (held + 1 - window), one drop step per cycle through the
// sorted cell chains, one insert step, one median pick into the output register.
// reset empties the chains at once, clears the held count and loads window length 5.
// a result waiting on m_tready does not block the next input word; the median step
// holds until the output register is free.
module sliding_median_three_axis #(
  parameter int WINDOW_MAX  = smm_pkg::WINDOW_MAX_DEF,
  parameter int SAMPLE_BITS = smm_pkg::SAMPLE_BITS_DEF,
  localparam int DATA_W     = ((3 * SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  input  logic [DATA_W-1:0]        s_tdata,   // sample_x, sample_y, sample_z
  output logic                     m_tvalid,
  input  logic                     m_tready,
  output logic [DATA_W-1:0]        m_tdata,   // median_x, median_y, median_z
  input  logic                     cfg_we,
  input  logic [smm_pkg::CFG_W-1:0] cfg_wdata // window_length
);
  import smm_pkg::*;

  localparam int CNT_W = $clog2(WINDOW_MAX + 1);
  localparam int AGE_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int SB    = SAMPLE_BITS;

  smm_state_t              state, state_next;
  logic [CFG_W-1:0]        window_length;
  logic [CNT_W-1:0]        count, count_next;
  logic [CNT_W-1:0]        win_eff;
  logic [CMP_W-1:0]        win_wide;
  logic [CNT_W-1:0]        count_dec;
  logic [AGE_W-1:0]        del_age;
  smm_ctl_t                ctl;
  logic                    out_load;
  logic signed [SB-1:0]    sample [AXES];
  logic signed [SB-1:0]    median [AXES];
  logic [DATA_W-1:0]       out_word;

  // window length register
  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= WINDOW_RESET;
    end else if (cfg_we) begin
      window_length <= cfg_wdata;
    end
  end

  // clamp window to 1..WINDOW_MAX
  assign win_wide = CMP_W'(window_length);
  always_comb begin
    if (window_length == '0) begin
      win_eff = CNT_W'(1);
    end else if (win_wide > CMP_W'(WINDOW_MAX)) begin
      win_eff = CNT_W'(WINDOW_MAX);
    end else begin
      win_eff = win_wide[CNT_W-1:0];
    end
  end

  assign count_dec = count - 1'b1;
  assign del_age   = count_dec[AGE_W-1:0];
  assign s_tready  = (state == ST_IDLE);

  // sequencer
  always_comb begin
    state_next = state;
    count_next = count;
    ctl        = '0;
    out_load   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_DROP;
      end
      ST_DROP: begin
        if (count >= win_eff) begin
          ctl.delete = 1'b1;
          count_next = count_dec;
          if (count == win_eff) state_next = ST_INSERT;
        end else begin
          state_next = ST_INSERT;
        end
      end
      ST_INSERT: begin
        ctl.insert = 1'b1;
        count_next = count + 1'b1;
        state_next = ST_MEDIAN;
      end
      ST_MEDIAN: begin
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // input word capture
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      for (int a = 0; a < AXES; a++) begin
        sample[a] <= s_tdata[a*SB +: SB];
      end
    end
  end

  // one sorted chain per axis
  for (genvar a = 0; a < AXES; a++) begin : g_axis
    smm_chain #(
      .WINDOW_MAX (WINDOW_MAX),
      .SAMPLE_BITS(SAMPLE_BITS),
      .CNT_W      (CNT_W),
      .AGE_W      (AGE_W)
    ) u_chain (
      .clk      (clk),
      .rst      (rst),
      .ctl      (ctl),
      .new_value(sample[a]),
      .del_age  (del_age),
      .count    (count),
      .median   (median[a])
    );
  end

  // pack the three medians, pad bits zero
  always_comb begin
    out_word = '0;
    for (int a = 0; a < AXES; a++) begin
      out_word[a*SB +: SB] = median[a];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= out_word;
    end
  end

endmodule

// ===== rtl/core/smm_cell.sv =====
// one cell of a sorted sample chain: holds a value, its age and a valid bit
module smm_cell #(
  parameter int SAMPLE_BITS = 16,
  parameter int AGE_W       = 4
) (
  input  logic                          clk,
  input  logic                          rst,
  input  smm_pkg::smm_ctl_t             ctl,
  input  logic signed [SAMPLE_BITS-1:0] new_value,
  input  logic [AGE_W-1:0]              del_age,
  input  logic                          left_valid,
  input  logic signed [SAMPLE_BITS-1:0] left_value,
  input  logic [AGE_W-1:0]              left_age,
  input  logic                          left_gt,
  input  logic                          left_del,
  input  logic                          right_valid,
  input  logic signed [SAMPLE_BITS-1:0] right_value,
  input  logic [AGE_W-1:0]              right_age,
  output logic                          valid,
  output logic signed [SAMPLE_BITS-1:0] value,
  output logic [AGE_W-1:0]              age,
  output logic                          gt,
  output logic                          del
);
  import smm_pkg::*;

  logic                          valid_next;
  logic signed [SAMPLE_BITS-1:0] value_next;
  logic [AGE_W-1:0]              age_next;

  // new sample sorts before this cell; empty cells count as plus infinity
  assign gt  = !valid || (new_value < value);
  // oldest entry sits here or further left
  assign del = left_del || (valid && (age == del_age));

  // shift toward the neighbors
  always_comb begin
    valid_next = valid;
    value_next = value;
    age_next   = age;
    if (ctl.delete && del) begin
      valid_next = right_valid;
      value_next = right_value;
      age_next   = right_age;
    end else if (ctl.insert) begin
      if (gt && !left_gt) begin
        valid_next = 1'b1;
        value_next = new_value;
        age_next   = '0;
      end else if (gt) begin
        valid_next = left_valid;
        value_next = left_value;
        age_next   = left_age + 1'b1;
      end else begin
        age_next   = age + 1'b1;
      end
    end
  end

  // valid bit is control, payload needs no reset
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    value <= value_next;
    age   <= age_next;
  end

endmodule

// ===== rtl/core/smm_chain.sv =====
// sorted chain of cells for one axis, with median pick from the held count
module smm_chain #(
  parameter int WINDOW_MAX  = 16,
  parameter int SAMPLE_BITS = 16,
  parameter int CNT_W       = 5,
  parameter int AGE_W       = 4
) (
  input  logic                          clk,
  input  logic                          rst,
  input  smm_pkg::smm_ctl_t             ctl,
  input  logic signed [SAMPLE_BITS-1:0] new_value,
  input  logic [AGE_W-1:0]              del_age,
  input  logic [CNT_W-1:0]              count,
  output logic signed [SAMPLE_BITS-1:0] median
);
  import smm_pkg::*;

  logic                          c_valid [WINDOW_MAX];
  logic signed [SAMPLE_BITS-1:0] c_value [WINDOW_MAX];
  logic [AGE_W-1:0]              c_age   [WINDOW_MAX];
  logic                          c_gt    [WINDOW_MAX];
  logic                          c_del   [WINDOW_MAX];

  // row of cells, each tied to both neighbors
  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    logic                          l_valid, l_gt, l_del, r_valid;
    logic signed [SAMPLE_BITS-1:0] l_value, r_value;
    logic [AGE_W-1:0]              l_age, r_age;

    if (i == 0) begin : g_head
      assign l_valid = 1'b0;
      assign l_value = '0;
      assign l_age   = '0;
      assign l_gt    = 1'b0;
      assign l_del   = 1'b0;
    end else begin : g_mid
      assign l_valid = c_valid[i-1];
      assign l_value = c_value[i-1];
      assign l_age   = c_age[i-1];
      assign l_gt    = c_gt[i-1];
      assign l_del   = c_del[i-1];
    end

    if (i == WINDOW_MAX - 1) begin : g_tail
      assign r_valid = 1'b0;
      assign r_value = '0;
      assign r_age   = '0;
    end else begin : g_body
      assign r_valid = c_valid[i+1];
      assign r_value = c_value[i+1];
      assign r_age   = c_age[i+1];
    end

    smm_cell #(
      .SAMPLE_BITS(SAMPLE_BITS),
      .AGE_W      (AGE_W)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .new_value  (new_value),
      .del_age    (del_age),
      .left_valid (l_valid),
      .left_value (l_value),
      .left_age   (l_age),
      .left_gt    (l_gt),
      .left_del   (l_del),
      .right_valid(r_valid),
      .right_value(r_value),
      .right_age  (r_age),
      .valid      (c_valid[i]),
      .value      (c_value[i]),
      .age        (c_age[i]),
      .gt         (c_gt[i]),
      .del        (c_del[i])
    );
  end

  // middle pair positions in the sorted row
  logic [CNT_W-1:0]              pos_hi;
  logic [CNT_W-1:0]              pos_lo;
  logic signed [SAMPLE_BITS-1:0] mid_hi;
  logic signed [SAMPLE_BITS-1:0] mid_lo;
  logic signed [SAMPLE_BITS:0]   pair_sum;

  assign pos_hi = count >> 1;
  assign pos_lo = pos_hi - 1'b1;

  // and-or pick of the two middle cells
  always_comb begin
    mid_hi = '0;
    mid_lo = '0;
    for (int i = 0; i < WINDOW_MAX; i++) begin
      if (pos_hi == CNT_W'(i)) mid_hi = mid_hi | c_value[i];
      if (pos_lo == CNT_W'(i)) mid_lo = mid_lo | c_value[i];
    end
  end

  // even count: floor of the pair mean
  assign pair_sum = {mid_lo[SAMPLE_BITS-1], mid_lo} + {mid_hi[SAMPLE_BITS-1], mid_hi};
  assign median   = count[0] ? mid_hi : pair_sum[SAMPLE_BITS:1];

endmodule

// ===== rtl/core/smm_check.sv =====
// port-level checks for the sliding median filter, bound to the top level
module smm_check #(
  parameter int DATA_W = 48
) (
  input logic              clk,
  input logic              rst,
  input logic              s_tvalid,
  input logic              s_tready,
  input logic              m_tvalid,
  input logic              m_tready,
  input logic [DATA_W-1:0] m_tdata
);

  // a stalled result keeps its data
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

  // one word at a time: input closes after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while busy");

  // a new result cannot appear before the drop and insert steps of an accepted word
  a_min_latency: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !$rose(m_tvalid) ##1 !$rose(m_tvalid))
    else $error("result too early");

  // a fresh result coincides with the input opening again
  a_result_frees_input: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> s_tready)
    else $error("input closed when result appeared");

endmodule

bind sliding_median_three_axis smm_check #(.DATA_W(DATA_W)) u_smm_check (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ===== verif/smm_median_checker.sv =====
// checker for the sliding median filter: window predictor and result compare
module smm_median_checker (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  input  logic                      s_tready,
  input  logic [47:0]               s_tdata,   // sample_x, sample_y, sample_z
  input  logic                      m_tvalid,
  input  logic                      m_tready,
  input  logic [47:0]               m_tdata,   // median_x, median_y, median_z
  input  logic                      cfg_we,
  input  logic [smm_pkg::CFG_W-1:0] cfg_wdata, // window_length
  output int                        fail_count,
  output int                        outstanding,
  output int                        medians_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WIN_MAX = 16;
  localparam int SB      = 16;
  localparam int NAXES   = smm_pkg::AXES;

  typedef logic signed [SB-1:0] sample_t;

  // shadow copy of the window ring and its bookkeeping
  sample_t                   ring [WIN_MAX][NAXES];
  logic [3:0]                head;
  logic [4:0]                held;
  logic [smm_pkg::CFG_W-1:0] win_len;

  // medians still owed by the block, oldest first
  logic [47:0] median_q [$];
  logic [47:0] predicted;
  logic [47:0] owed;
  string       axis_name [NAXES] = '{"x", "y", "z"};

  task automatic report_mismatch(input string msg);
    fail_count++;
    $display("[%0t] median check: %s", $realtime, msg);
  endtask

  // median of one axis over the held samples, middle pair averaged toward -inf
  function automatic sample_t axis_median(input int axis);
    int vals [WIN_MAX];
    int n;
    int i;
    int j;
    int key;
    n = held;
    for (i = 0; i < n; i++)
      vals[i] = ring[(int'(head) + i) % WIN_MAX][axis];
    for (i = 1; i < n; i++) begin
      key = vals[i];
      j = i;
      while (j > 0 && vals[j-1] > key) begin
        vals[j] = vals[j-1];
        j--;
      end
      vals[j] = key;
    end
    if (n % 2 == 1)
      return sample_t'(vals[n/2]);
    return sample_t'((vals[n/2-1] + vals[n/2]) >>> 1);
  endfunction

  // store a new sample, trim to the window, work out the three medians
  task automatic absorb_sample(input logic [47:0] word, output logic [47:0] med);
    logic [4:0] eff;
    logic [3:0] slot;
    int         a;
    if (win_len == 0)
      eff = 5'd1;
    else if (win_len > WIN_MAX)
      eff = 5'(WIN_MAX);
    else
      eff = win_len;
    if (held < WIN_MAX) begin
      slot = head + held[3:0];
      held = held + 5'd1;
    end else begin
      slot = head;
      head = head + 4'd1;
    end
    for (a = 0; a < NAXES; a++)
      ring[slot][a] = word[SB*a +: SB];
    // a shrunk window drops several of the oldest at once
    while (held > eff) begin
      head = head + 4'd1;
      held = held - 5'd1;
    end
    for (a = 0; a < NAXES; a++)
      med[SB*a +: SB] = axis_median(a);
  endtask

  // watch the channels at each edge
  always @(posedge clk) begin
    if (rst) begin
      head            = '0;
      held            = '0;
      win_len         = smm_pkg::WINDOW_RESET;
      fail_count      = 0;
      medians_checked = 0;
      median_q.delete();
    end else begin
      if (cfg_we)
        win_len = cfg_wdata;
      if (s_tvalid && s_tready) begin
        absorb_sample(s_tdata, predicted);
        median_q.insert(median_q.size(), predicted);
      end
      if (m_tvalid && m_tready) begin
        if (median_q.size() == 0) begin
          report_mismatch($sformatf("median word %h with no sample pending", m_tdata));
        end else begin
          owed = median_q[0];
          median_q.delete(0);
          for (int a = 0; a < NAXES; a++) begin
            if (m_tdata[SB*a +: SB] !== owed[SB*a +: SB])
              report_mismatch($sformatf("word %0d median_%s got %0d expected %0d",
                medians_checked, axis_name[a], $signed(m_tdata[SB*a +: SB]),
                $signed(owed[SB*a +: SB])));
          end
          medians_checked++;
        end
      end
    end
    outstanding = median_q.size();
  end

endmodule

// ===== verif/tb_sliding_median_three_axis.sv =====
// testbench top for the three-axis sliding median filter
module tb_sliding_median_three_axis;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DATA_W      = 48;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int TARGET      = 1900;
  localparam int SETTLE      = 24;

  typedef enum int {RX_OPEN, RX_COIN, RX_LONG_STALL, RX_ALTERNATE} rx_mode_t;

  logic                      clk;
  logic                      rst       = 1'b1;
  logic                      s_tvalid  = 1'b0;
  logic                      s_tready;
  logic [DATA_W-1:0]         s_tdata   = '0;  // sample_x, sample_y, sample_z
  logic                      m_tvalid;
  logic                      m_tready  = 1'b0;
  logic [DATA_W-1:0]         m_tdata;         // median_x, median_y, median_z
  logic                      cfg_we    = 1'b0;
  logic [smm_pkg::CFG_W-1:0] cfg_wdata = '0;  // window_length

  int fail_count;
  int outstanding;
  int medians_checked;
  int cycles       = 0;
  int samples_sent = 0;
  int windows_used = 0;
  int burst_left   = 0;
  bit gaps_on      = 1'b0;

  int       rx_cycle = 0;
  int       rx_stall = 0;
  rx_mode_t rx_mode  = RX_OPEN;
  logic     rx_next;

  logic [15:0] extremes [6] = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h7FFE, 16'h8001};
  logic [4:0]  schedule [8] = '{5'd16, 5'd1, 5'd17, 5'd4, 5'd0, 5'd15, 5'd31, 5'd3};

  // clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  sliding_median_three_axis DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  smm_median_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .s_tdata         (s_tdata),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .fail_count      (fail_count),
    .outstanding     (outstanding),
    .medians_checked (medians_checked)
  );

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d medians still owed", cycles, outstanding);
      $display("sliding_median_three_axis: mismatch");
      $finish;
    end
  end

  // receiver backpressure, pattern redrawn periodically at random
  always @(posedge clk) begin
    if (rx_cycle % 300 == 0)
      rx_mode = rx_mode_t'($urandom_range(0, 3));
    rx_cycle++;
    if (rx_stall > 0) begin
      rx_stall--;
      rx_next = 1'b0;
    end else begin
      case (rx_mode)
        RX_OPEN: begin
          rx_next = 1'b1;
        end
        RX_COIN: begin
          rx_next = 1'($urandom_range(0, 1));
        end
        RX_LONG_STALL: begin
          rx_next = 1'b1;
          if ($urandom_range(0, 39) == 0) begin
            rx_stall = $urandom_range(4, 24);
            rx_next  = 1'b0;
          end
        end
        default: begin
          rx_next = rx_cycle[0];
        end
      endcase
    end
    m_tready <= rx_next;
  end

  function automatic logic [DATA_W-1:0] pack_axes(input logic [15:0] x, input logic [15:0] y,
                                                  input logic [15:0] z);
    return {z, y, x};
  endfunction

  // mostly full range, some near-ties, some rail values
  function automatic logic [15:0] rand_axis();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60)
      return 16'($urandom);
    if (r < 85)
      return 16'($urandom_range(0, 8) - 4);
    return extremes[$urandom_range(0, 5)];
  endfunction

  // offer one sample word and hold it until taken
  task automatic push_sample(input logic [DATA_W-1:0] word);
    s_tvalid <= 1'b1;
    s_tdata  <= word;
    do @(posedge clk); while (!s_tready);
    samples_sent++;
  endtask

  // sender gaps between bursts
  task automatic maybe_pause();
    if (gaps_on) begin
      if (burst_left == 0) begin
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
        burst_left = $urandom_range(1, 30);
      end else begin
        burst_left--;
      end
    end
  endtask

  // stop sending and wait for every owed median, then let the pipe empty
  task automatic drain();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_window(input logic [4:0] w);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_we    <= 1'b0;
    windows_used++;
  endtask

  initial begin
    int phase;
    int phase_len;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset window of five: rails, sign flips, even-count averaging while filling
    push_sample(pack_axes(16'h7FFF, 16'h8000, 16'h0000));
    push_sample(pack_axes(16'h8000, 16'h7FFF, 16'hFFFF));
    push_sample(pack_axes(16'h7FFF, 16'h7FFF, 16'h0001));
    push_sample(pack_axes(16'h8000, 16'h8000, 16'h7FFF));
    push_sample(pack_axes(16'h0000, 16'hFFFF, 16'h8000));
    push_sample(pack_axes(16'h0001, 16'h0001, 16'h5555));
    push_sample(pack_axes(16'hFFFF, 16'h0001, 16'hAAAA));
    push_sample(pack_axes(16'h5555, 16'hAAAA, 16'h0000));

    // zero window behaves as one
    set_window(5'd0);
    push_sample(pack_axes(16'h8000, 16'h7FFF, 16'h1234));
    push_sample(pack_axes(16'h7FFF, 16'h8000, 16'hEDCB));
    push_sample(pack_axes(16'hFFFF, 16'h0000, 16'h0001));

    // grow to two: even pair straddling zero
    set_window(5'd2);
    push_sample(pack_axes(16'h8000, 16'h7FFF, 16'hFFFF));
    push_sample(pack_axes(16'h7FFF, 16'h8000, 16'hFFFE));
    push_sample(pack_axes(16'hFFFF, 16'h0000, 16'h0003));

    // oversized window saturates at sixteen
    set_window(5'd31);
    for (int i = 0; i < 10; i++)
      push_sample(pack_axes(extremes[i % 6], extremes[(i + 2) % 6], 16'(i * 16'h1111)));

    // random phases, each with its own window and sender behavior
    phase = 0;
    while (samples_sent < TARGET) begin
      set_window(phase < 8 ? schedule[phase] : 5'($urandom_range(0, 31)));
      phase_len  = $urandom_range(20, 100);
      gaps_on    = ($urandom_range(0, 3) != 0);
      burst_left = $urandom_range(1, 30);
      for (int i = 0; i < phase_len; i++) begin
        push_sample(pack_axes(rand_axis(), rand_axis(), rand_axis()));
        maybe_pause();
      end
      phase++;
    end

    drain();
    $display("sent %0d sample words over %0d window settings, checked %0d median words",
             samples_sent, windows_used, medians_checked);
    $display("windows covered zero, one, sixteen and saturating values, grown and shrunk");
    if (fail_count == 0)
      $display("sliding_median_three_axis: match");
    else
      $display("sliding_median_three_axis: mismatch");
    $finish;
  end

endmodule
